FILE: src/mlls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlls_pkg: shared types and constants for the multi-list linked store
// Field widths of the transaction ports, operation and status codes, the
// sequencer state type and the result record.
// ----------------------------------------------------------------------------
package mlls_pkg;

  // Field widths of the transaction ports.
  localparam int FUNC_W  = 2;
  localparam int LIST_W  = 6;
  localparam int POS_W   = 10;
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 11;
  localparam int NODE_W  = 10;
  localparam int STAT_W  = 2;

  // Operation codes. The unused code behaves as a count query.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_COUNT  = 2'd2
  } func_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LIST = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_BAD_POS  = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_LINK,
    ST_WALK,
    ST_FINISH
  } state_t;

  // One result transaction.
  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [LEN_W-1:0]          list_length;
    logic [NODE_W-1:0]         node_index;
    status_t                   status;
  } result_t;

endpackage
`default_nettype wire

FILE: src/mlls_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlls_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module mlls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: src/mlls_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlls_seq: operation sequencer for the multi-list linked store
// Clears the list table after reset, looks up the addressed list, performs
// appends as a read-modify-write of the old tail node and walks node links
// one per cycle for reads. Holds the fill pointer and the read cursor.
// ----------------------------------------------------------------------------
module mlls_seq
  import mlls_pkg::*;
#(
  parameter int NODES = 1024,
  parameter int LISTS = 64
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  // Incoming transaction
  input  wire logic                                         in_valid,
  output logic                                              in_ready,
  input  wire logic [FUNC_W-1:0]                            func,
  input  wire logic [LIST_W-1:0]                            list_id,
  input  wire logic [POS_W-1:0]                             position,
  input  wire logic signed [VALUE_W-1:0]                    item_value,
  // List table RAM
  output logic                                              lt_we,
  output logic [((LISTS > 1) ? $clog2(LISTS) : 1)-1:0]      lt_waddr,
  output logic [$clog2(NODES+1)+2*$clog2(NODES)-1:0]        lt_wdata,
  output logic [((LISTS > 1) ? $clog2(LISTS) : 1)-1:0]      lt_raddr,
  input  wire logic [$clog2(NODES+1)+2*$clog2(NODES)-1:0]   lt_rdata,
  // Node store RAM
  output logic                                              nd_we,
  output logic [$clog2(NODES)-1:0]                          nd_waddr,
  output logic [$clog2(NODES)+VALUE_W-1:0]                  nd_wdata,
  output logic [$clog2(NODES)-1:0]                          nd_raddr,
  input  wire logic [$clog2(NODES)+VALUE_W-1:0]             nd_rdata,
  // Finished result
  output logic                                              res_valid,
  input  wire logic                                         res_take,
  output result_t                                           res
);

  localparam int NodeAw = $clog2(NODES);
  localparam int CntW   = $clog2(NODES + 1);
  localparam int ListAw = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int LtW    = CntW + 2 * NodeAw;
  localparam int NdW    = NodeAw + VALUE_W;

  state_t                     state_r, state_nxt;
  logic [CntW-1:0]            fill_r, fill_nxt;
  logic [LIST_W-1:0]          cur_list_r, cur_list_nxt;
  logic [NodeAw-1:0]          cur_pos_r, cur_pos_nxt;
  logic [NodeAw-1:0]          cur_node_r, cur_node_nxt;
  logic [ListAw-1:0]          clr_r, clr_nxt;
  logic [FUNC_W-1:0]          func_r, func_nxt;
  logic [LIST_W-1:0]          lst_r, lst_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic signed [VALUE_W-1:0]  val_r, val_nxt;
  logic [NodeAw-1:0]          node_r, node_nxt;
  logic [NodeAw-1:0]          tail_r, tail_nxt;
  logic [NodeAw-1:0]          steps_r, steps_nxt;
  result_t                    res_r, res_nxt;

  // Fields of the list table entry and of the node entry.
  logic [CntW-1:0]            lt_cnt;
  logic [NodeAw-1:0]          lt_head;
  logic [NodeAw-1:0]          lt_tail;
  logic [NodeAw-1:0]          nd_link;
  logic [VALUE_W-1:0]         nd_value;

  // Decoded conditions of the lookup cycle.
  logic                       list_ok;
  logic                       store_full;
  logic                       pos_ok;
  logic                       cursor_hit;
  logic [NodeAw-1:0]          fresh;
  logic [NodeAw-1:0]          pos_n;

  assign lt_cnt   = lt_rdata[LtW-1 -: CntW];
  assign lt_head  = lt_rdata[2*NodeAw-1 -: NodeAw];
  assign lt_tail  = lt_rdata[NodeAw-1:0];
  assign nd_link  = nd_rdata[NdW-1 -: NodeAw];
  assign nd_value = nd_rdata[VALUE_W-1:0];

  assign list_ok    = (32'(lst_r) < 32'(LISTS));
  assign store_full = (fill_r == CntW'(NODES));
  assign pos_ok     = (32'(pos_r) < 32'(lt_cnt));
  assign fresh      = NodeAw'(fill_r);
  assign pos_n      = NodeAw'(pos_r);
  assign cursor_hit = (cur_list_r == lst_r) && (cur_pos_r <= pos_n);

  assign res = res_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers: fill pointer, read cursor and clearing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      cur_list_r <= '0;
      cur_pos_r  <= '0;
      cur_node_r <= '0;
      clr_r      <= '0;
    end else begin
      fill_r     <= fill_nxt;
      cur_list_r <= cur_list_nxt;
      cur_pos_r  <= cur_pos_nxt;
      cur_node_r <= cur_node_nxt;
      clr_r      <= clr_nxt;
    end
  end

  // Transaction payload and working registers.
  always_ff @(posedge clk) begin
    func_r  <= func_nxt;
    lst_r   <= lst_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    node_r  <= node_nxt;
    tail_r  <= tail_nxt;
    steps_r <= steps_nxt;
    res_r   <= res_nxt;
  end

  // Next state, memory accesses and results.
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    cur_list_nxt = cur_list_r;
    cur_pos_nxt  = cur_pos_r;
    cur_node_nxt = cur_node_r;
    clr_nxt      = clr_r;
    func_nxt     = func_r;
    lst_nxt      = lst_r;
    pos_nxt      = pos_r;
    val_nxt      = val_r;
    node_nxt     = node_r;
    tail_nxt     = tail_r;
    steps_nxt    = steps_r;
    res_nxt      = res_r;

    in_ready  = 1'b0;
    res_valid = 1'b0;
    lt_we     = 1'b0;
    lt_waddr  = ListAw'(lst_r);
    lt_wdata  = '0;
    lt_raddr  = ListAw'(lst_r);
    nd_we     = 1'b0;
    nd_waddr  = fresh;
    nd_wdata  = {{NodeAw{1'b0}}, val_r};
    nd_raddr  = node_r;

    unique case (state_r)
      // Zero every list count after reset, one entry per cycle.
      ST_CLEAR: begin
        lt_we    = 1'b1;
        lt_waddr = clr_r;
        lt_wdata = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == ListAw'(LISTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      // Take a transaction and start the list table read.
      ST_IDLE: begin
        in_ready = 1'b1;
        lt_raddr = ListAw'(list_id);
        if (in_valid) begin
          func_nxt  = func;
          lst_nxt   = list_id;
          pos_nxt   = position;
          val_nxt   = item_value;
          state_nxt = ST_LOOKUP;
        end
      end

      // The list entry is available: decide the operation.
      ST_LOOKUP: begin
        res_nxt.read_value  = '0;
        res_nxt.list_length = LEN_W'(lt_cnt);
        res_nxt.node_index  = '0;
        res_nxt.status      = STAT_OK;
        state_nxt           = ST_FINISH;
        if (!list_ok) begin
          res_nxt.list_length = '0;
          res_nxt.status      = STAT_BAD_LIST;
        end else begin
          unique case (func_r)
            FUNC_APPEND: begin
              if (store_full) begin
                res_nxt.status = STAT_FULL;
              end else begin
                // The new node is written now; its link is never followed.
                nd_we               = 1'b1;
                nd_waddr            = fresh;
                nd_wdata            = {{NodeAw{1'b0}}, val_r};
                lt_we               = 1'b1;
                lt_waddr            = ListAw'(lst_r);
                fill_nxt            = fill_r + 1'b1;
                node_nxt            = fresh;
                cur_list_nxt        = lst_r;
                res_nxt.list_length = LEN_W'(lt_cnt + 1'b1);
                res_nxt.node_index  = NODE_W'(fresh);
                if (lt_cnt == '0) begin
                  lt_wdata     = {lt_cnt + 1'b1, fresh, fresh};
                  cur_pos_nxt  = '0;
                  cur_node_nxt = fresh;
                end else begin
                  // Fetch the old tail so that its link can be rewritten.
                  lt_wdata     = {lt_cnt + 1'b1, lt_head, fresh};
                  cur_pos_nxt  = NodeAw'(lt_cnt - 1'b1);
                  cur_node_nxt = lt_tail;
                  tail_nxt     = lt_tail;
                  nd_raddr     = lt_tail;
                  state_nxt    = ST_LINK;
                end
              end
            end
            FUNC_READ: begin
              if (!pos_ok) begin
                res_nxt.status = STAT_BAD_POS;
              end else begin
                // Walk from the cursor when reading forward in its list.
                cur_list_nxt = lst_r;
                cur_pos_nxt  = pos_n;
                if (cursor_hit) begin
                  node_nxt  = cur_node_r;
                  nd_raddr  = cur_node_r;
                  steps_nxt = pos_n - cur_pos_r;
                end else begin
                  node_nxt  = lt_head;
                  nd_raddr  = lt_head;
                  steps_nxt = pos_n;
                end
                state_nxt = ST_WALK;
              end
            end
            default: begin
              // Count query: the length is already set.
            end
          endcase
        end
      end

      // Link the old tail to the new node, keeping the tail's value.
      ST_LINK: begin
        nd_we     = 1'b1;
        nd_waddr  = tail_r;
        nd_wdata  = {node_r, nd_value};
        state_nxt = ST_FINISH;
      end

      // One link per cycle; the data of node_r is on the read port.
      ST_WALK: begin
        if (steps_r == '0) begin
          res_nxt.read_value = signed'(nd_value);
          res_nxt.node_index = NODE_W'(node_r);
          cur_node_nxt       = node_r;
          state_nxt          = ST_FINISH;
        end else begin
          node_nxt  = nd_link;
          nd_raddr  = nd_link;
          steps_nxt = steps_r - 1'b1;
        end
      end

      // Hand the result to the output register.
      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The walk counts down by one per cycle.
  a_walk_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && (steps_r != '0) |=>
      (state_r == ST_WALK) && (steps_r == NodeAw'($past(steps_r) - 1'b1)))
    else $error("walk step counter did not count down");

  // A finished walk leaves the cursor on the position read.
  a_cursor_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && (steps_r == '0) |=>
      (cur_pos_r == NodeAw'(pos_r)) && (cur_list_r == lst_r))
    else $error("cursor does not match the finished read");

  // The fill pointer never passes the store size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CntW'(NODES))
    else $error("fill pointer beyond the node store");

  // A successful append advances the fill pointer by exactly one.
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) && list_ok && (func_r == FUNC_APPEND) && !store_full |=>
      fill_r == CntW'($past(fill_r) + 1'b1))
    else $error("append did not advance the fill pointer");

endmodule
`default_nettype wire

FILE: src/mlls_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlls_out: result output register
// Holds one finished result on the output ports until it is taken, and
// accepts the next result in the cycle the current one leaves.
// ----------------------------------------------------------------------------
module mlls_out
  import mlls_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                res_valid,
  output logic                     res_take,
  input  wire result_t             res,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [VALUE_W-1:0] out_read_value,
  output logic [LEN_W-1:0]         out_list_length,
  output logic [NODE_W-1:0]        out_node_index,
  output logic [STAT_W-1:0]        out_status
);

  logic    out_valid_r;
  result_t out_r;

  // The register is free when empty or when its transaction leaves now.
  assign res_take = !out_valid_r || !out_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_r.read_value;
  assign out_list_length = out_r.list_length;
  assign out_node_index  = out_r.node_index;
  assign out_status      = out_r.status;

endmodule
`default_nettype wire

FILE: src/multi_list_linked_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_list_linked_store: linked lists sharing one bump-allocated node store
// Appends values to lists, reads elements by position through a forward
// cursor and reports list lengths, with one result per transaction.
//
//   Channel  Direction  Handshake           Fields
//   in_      input      in_valid/in_stall   func, list_id, position, item_value
//   out_     output     out_valid/out_stall read_value, list_length,
//                                           node_index, status
//
// Every transaction reads its list table entry first. A count query, an error
// and an append to an empty list then finish; any other append also rewrites
// the link of the old tail node, and a read walks steps links from the
// cursor or the list head (one link per cycle on the node store read port).
// The result enters the output register as the sequencer returns to idle,
// where the next transaction can be accepted.
// After reset the list table is cleared entry by entry; in_stall is high
// during that time.
// A held result does not block the next transaction; a finished result waits
// in the sequencer while out_stall keeps the output register full.
// ----------------------------------------------------------------------------
module multi_list_linked_store
  import mlls_pkg::*;
#(
  parameter int NODES = 1024,
  parameter int LISTS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [FUNC_W-1:0]         in_func,
  input  wire logic [LIST_W-1:0]         in_list_id,
  input  wire logic [POS_W-1:0]          in_position,
  input  wire logic signed [VALUE_W-1:0] in_item_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [VALUE_W-1:0]      out_read_value,
  output logic [LEN_W-1:0]               out_list_length,
  output logic [NODE_W-1:0]              out_node_index,
  output logic [STAT_W-1:0]              out_status
);

  localparam int NodeAw = $clog2(NODES);
  localparam int CntW   = $clog2(NODES + 1);
  localparam int ListAw = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int LtW    = CntW + 2 * NodeAw;
  localparam int NdW    = NodeAw + VALUE_W;

  logic              in_ready;
  logic              lt_we;
  logic [ListAw-1:0] lt_waddr;
  logic [LtW-1:0]    lt_wdata;
  logic [ListAw-1:0] lt_raddr;
  logic [LtW-1:0]    lt_rdata;
  logic              nd_we;
  logic [NodeAw-1:0] nd_waddr;
  logic [NdW-1:0]    nd_wdata;
  logic [NodeAw-1:0] nd_raddr;
  logic [NdW-1:0]    nd_rdata;
  logic              res_valid;
  logic              res_take;
  result_t           res;

  assign in_stall = !in_ready;

  // List table: count, head and tail of each list.
  mlls_ram #(
    .WIDTH (LtW),
    .DEPTH (LISTS)
  ) u_list_ram (
    .clk   (clk),
    .we    (lt_we),
    .waddr (lt_waddr),
    .wdata (lt_wdata),
    .raddr (lt_raddr),
    .rdata (lt_rdata)
  );

  // Node store: link and value of each node.
  mlls_ram #(
    .WIDTH (NdW),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .raddr (nd_raddr),
    .rdata (nd_rdata)
  );

  // Operation sequencer.
  mlls_seq #(
    .NODES (NODES),
    .LISTS (LISTS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (in_func),
    .list_id    (in_list_id),
    .position   (in_position),
    .item_value (in_item_value),
    .lt_we      (lt_we),
    .lt_waddr   (lt_waddr),
    .lt_wdata   (lt_wdata),
    .lt_raddr   (lt_raddr),
    .lt_rdata   (lt_rdata),
    .nd_we      (nd_we),
    .nd_waddr   (nd_waddr),
    .nd_wdata   (nd_wdata),
    .nd_raddr   (nd_raddr),
    .nd_rdata   (nd_rdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // Output register.
  mlls_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res             (res),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_list_length (out_list_length),
    .out_node_index  (out_node_index),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire
